// ----- rtl/core/tmor_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmor_pkg: shared types and codes for the TCP MSS option range match
// Item, result and configuration structures, register indexes and item codes.
// ----------------------------------------------------------------------------
package tmor_pkg;

  // item codes
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_OPTION = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_MSS_LOWER    = 2'd0;
  localparam logic [1:0] REG_MSS_UPPER    = 2'd1;
  localparam logic [1:0] REG_INVERT_SENSE = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0] KIND_MSS = 8'd2;
  localparam logic [7:0] LEN_MSS  = 8'd4;
  localparam logic [3:0] MIN_DATA_OFFSET = 4'd5;

  typedef struct packed {
    logic       op;
    logic [3:0] data_offset;
    logic       header_complete;
    logic [7:0] option_byte;
    logic       last_available;
  } item_t;

  typedef struct packed {
    logic matched;
    logic drop;
  } result_t;

  typedef struct packed {
    logic [15:0] mss_lower;
    logic [15:0] mss_upper;
    logic        invert_sense;
  } cfg_t;

endpackage

// ----- rtl/core/tmor_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmor_stream_if: valid/ready stream channel
// Carries one payload per transfer; a transfer completes when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface tmor_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/tcp_mss_option_range_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_mss_option_range_match: streaming TCP MSS option range match
// Walks the TCP options of each packet and gives one verdict per packet.
//
//   channel  dir  payload                                          handshake
//   in_if    in   op, data_offset, header_complete, option_byte,   valid/ready
//                 last_available
//   out_if   out  matched, drop                                    valid/ready
//   cfg_*    in   cfg_index, cfg_wdata                             cfg_we
//
// One item per cycle sustained while out_if accepts results. An item passes the
// input register, then the walker logic, and its verdict (if any) lands in the
// result register. Reset is synchronous and leaves the walker idle with default
// limits. A stalled result register holds the input stage; with both full,
// in_if.ready drops until out_if transfers.
// ----------------------------------------------------------------------------
module tcp_mss_option_range_match
  import tmor_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  tmor_stream_if.sink            in_if,
  tmor_stream_if.source          out_if,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t    cfg_r;
  item_t   s1_r;
  logic    s1_valid_r;
  result_t out_r;
  logic    out_valid_r;
  logic    advance;
  logic    step;
  logic    emit;
  result_t res;

  // the result register can take a new verdict this cycle
  assign advance      = !out_valid_r || out_if.ready;
  assign in_if.ready  = !s1_valid_r || advance;
  assign step         = s1_valid_r && advance;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mss_lower    <= 16'h0000;
      cfg_r.mss_upper    <= 16'hFFFF;
      cfg_r.invert_sense <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MSS_LOWER:    cfg_r.mss_lower    <= cfg_wdata;
        REG_MSS_UPPER:    cfg_r.mss_upper    <= cfg_wdata;
        REG_INVERT_SENSE: cfg_r.invert_sense <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_r <= in_if.data;
    end
  end

  tmor_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_r),
    .cfg   (cfg_r),
    .emit  (emit),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_r <= res;
    end
  end

  // drop always carries a cleared match
  a_drop_clears_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.drop |-> !out_r.matched)
    else $error("drop verdict with matched set");

  // an incomplete header gives a drop verdict on the next cycle
  a_incomplete_drops: assert property (@(posedge clk) disable iff (!rst_n)
    step && (s1_r.op == OP_HEADER) && !s1_r.header_complete
    |=> out_valid_r && out_r.drop)
    else $error("incomplete header did not drop");

  // with an empty result register the input side is never stalled
  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_if.ready)
    else $error("input stalled with empty result register");

  // a verdict is only loaded when an item advances
  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step && emit))
    else $error("result appeared without an item");

endmodule

// ----- rtl/core/tmor_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmor_walker: TCP option walker and MSS range check
// Holds the per-packet parse state and decides, one item per step, whether a
// verdict is due.
// ----------------------------------------------------------------------------
module tmor_walker
  import tmor_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    emit,
  output result_t res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_WALK  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_HI    = 3'd3;
  localparam logic [2:0] PH_LO    = 3'd4;
  localparam logic [2:0] PH_DRAIN = 3'd5;

  logic [5:0] options_length_r, options_length_nxt;
  logic [5:0] byte_position_r, byte_position_nxt;
  logic [8:0] next_option_start_r, next_option_start_nxt;
  logic [2:0] parse_phase_r, parse_phase_nxt;
  logic       candidate_is_mss_r, candidate_is_mss_nxt;
  logic [7:0] mss_high_byte_r, mss_high_byte_nxt;
  logic       verdict_held_r, verdict_held_nxt;
  logic       verdict_known_r, verdict_known_nxt;

  logic        open_pkt;
  logic [6:0]  pos_plus1;
  logic [15:0] mss_val;
  logic        in_range;

  assign open_pkt  = (parse_phase_r == PH_WALK) || (parse_phase_r == PH_LEN) ||
                     (parse_phase_r == PH_HI) || (parse_phase_r == PH_LO) ||
                     (parse_phase_r == PH_DRAIN);
  assign pos_plus1 = {1'b0, byte_position_r} + 7'd1;
  assign mss_val   = {mss_high_byte_r, item.option_byte};
  assign in_range  = (mss_val >= cfg.mss_lower) && (mss_val <= cfg.mss_upper);

  always_comb begin
    options_length_nxt    = options_length_r;
    byte_position_nxt     = byte_position_r;
    next_option_start_nxt = next_option_start_r;
    parse_phase_nxt       = parse_phase_r;
    candidate_is_mss_nxt  = candidate_is_mss_r;
    mss_high_byte_nxt     = mss_high_byte_r;
    verdict_held_nxt      = verdict_held_r;
    verdict_known_nxt     = verdict_known_r;
    emit                  = 1'b0;
    res                   = '0;

    if (step && (item.op == OP_HEADER)) begin
      // a new header abandons any open packet
      byte_position_nxt     = '0;
      next_option_start_nxt = '0;
      candidate_is_mss_nxt  = 1'b0;
      mss_high_byte_nxt     = '0;
      verdict_held_nxt      = 1'b0;
      verdict_known_nxt     = 1'b0;
      options_length_nxt    = '0;
      parse_phase_nxt       = PH_IDLE;
      if (!item.header_complete || (item.data_offset < MIN_DATA_OFFSET)) begin
        emit     = 1'b1;
        res.drop = 1'b1;
      end else begin
        options_length_nxt = {item.data_offset - MIN_DATA_OFFSET, 2'b00};
        if (item.data_offset == MIN_DATA_OFFSET) begin
          emit        = 1'b1;
          res.matched = cfg.invert_sense;
        end else if (item.last_available) begin
          emit     = 1'b1;
          res.drop = 1'b1;
        end else begin
          parse_phase_nxt = PH_WALK;
        end
      end
    end else if (step && open_pkt) begin
      case (parse_phase_r)
        PH_WALK: begin
          if ({3'b000, byte_position_r} == next_option_start_r) begin
            candidate_is_mss_nxt = (item.option_byte == KIND_MSS) &&
                                   ({1'b0, options_length_r} >=
                                    ({1'b0, byte_position_r} + 7'(LEN_MSS)));
            if (item.option_byte < KIND_MSS) begin
              next_option_start_nxt = {2'b00, pos_plus1};
            end else begin
              parse_phase_nxt = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (candidate_is_mss_r && (item.option_byte == LEN_MSS)) begin
            parse_phase_nxt = PH_HI;
          end else begin
            // length of zero or one: the option is taken to end with this byte
            if (item.option_byte <= 8'd1) begin
              next_option_start_nxt = {2'b00, pos_plus1};
            end else begin
              next_option_start_nxt = {3'b000, byte_position_r} +
                                      {1'b0, item.option_byte} - 9'd1;
            end
            parse_phase_nxt = PH_WALK;
          end
          candidate_is_mss_nxt = 1'b0;
        end
        PH_HI: begin
          mss_high_byte_nxt = item.option_byte;
          parse_phase_nxt   = PH_LO;
        end
        PH_LO: begin
          verdict_held_nxt  = in_range ^ cfg.invert_sense;
          verdict_known_nxt = 1'b1;
          parse_phase_nxt   = PH_DRAIN;
        end
        default: begin
        end
      endcase

      if (pos_plus1 >= {1'b0, options_length_r}) begin
        emit            = 1'b1;
        res.matched     = verdict_known_nxt ? verdict_held_nxt : cfg.invert_sense;
        parse_phase_nxt = PH_IDLE;
      end else if (item.last_available) begin
        emit            = 1'b1;
        res.drop        = 1'b1;
        parse_phase_nxt = PH_IDLE;
      end else begin
        byte_position_nxt = pos_plus1[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      options_length_r    <= '0;
      byte_position_r     <= '0;
      next_option_start_r <= '0;
      parse_phase_r       <= PH_IDLE;
      candidate_is_mss_r  <= 1'b0;
      mss_high_byte_r     <= '0;
      verdict_held_r      <= 1'b0;
      verdict_known_r     <= 1'b0;
    end else begin
      options_length_r    <= options_length_nxt;
      byte_position_r     <= byte_position_nxt;
      next_option_start_r <= next_option_start_nxt;
      parse_phase_r       <= parse_phase_nxt;
      candidate_is_mss_r  <= candidate_is_mss_nxt;
      mss_high_byte_r     <= mss_high_byte_nxt;
      verdict_held_r      <= verdict_held_nxt;
      verdict_known_r     <= verdict_known_nxt;
    end
  end

endmodule

// ----- test/tcp_mss_option_range_match_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_mss_option_range_match_test: self-checking bench for the MSS range match
// Drives header items and option bytes through the input stream, predicts the
// per-packet verdict with a local option walker, and compares every result
// transfer against the oldest prediction. Random idling on both channels, a
// long output hold-off, and several limit settings including the extremes.
// ----------------------------------------------------------------------------
module tcp_mss_option_range_match_test;
  import tmor_pkg::*;

  typedef enum logic [2:0] {
    WALK_IDLE, WALK_KIND, WALK_LEN, WALK_MSS_HI, WALK_MSS_LO, WALK_DRAIN
  } walk_phase_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  tmor_stream_if #(.payload_t(item_t))   in_if ();
  tmor_stream_if #(.payload_t(result_t)) out_if ();

  tcp_mss_option_range_match u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // local copy of the limits
  logic [15:0] lim_lo;
  logic [15:0] lim_hi;
  logic        lim_inv;

  // walker state
  logic [5:0]  opt_len;
  logic [5:0]  byte_pos;
  logic [8:0]  next_start;
  walk_phase_t walk_phase;
  logic        mss_cand;
  logic [7:0]  mss_hi_byte;
  logic        verdict_held;
  logic        verdict_known;

  result_t     verdict_q[$];
  logic [7:0]  opt_area[$];
  int unsigned useful_items;
  int          mismatches;
  bit          idle_on;
  bit          stall_on;
  bit          long_hold_req;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tcp_mss_option_range_match verification failed");
    $finish;
  end

  // Work out the verdict, if any, that one accepted item causes.
  task automatic predict_verdict(item_t it);
    int unsigned p;
    logic [15:0] mss;
    result_t     r;
    bit          emit;
    emit = 0;
    r    = '0;
    if (it.op == OP_HEADER) begin
      useful_items++;
      byte_pos      = '0;
      next_start    = '0;
      mss_cand      = 1'b0;
      mss_hi_byte   = '0;
      verdict_held  = 1'b0;
      verdict_known = 1'b0;
      opt_len       = '0;
      if (!it.header_complete || it.data_offset < MIN_DATA_OFFSET) begin
        r.drop = 1'b1;
        emit   = 1;
      end else begin
        opt_len = 6'((int'(it.data_offset) - int'(MIN_DATA_OFFSET)) * 4);
        if (opt_len == 0) begin
          r.matched = lim_inv;
          emit      = 1;
        end else if (it.last_available) begin
          r.drop = 1'b1;
          emit   = 1;
        end else begin
          walk_phase = WALK_KIND;
        end
      end
    end else if (walk_phase != WALK_IDLE) begin
      useful_items++;
      p = byte_pos;
      case (walk_phase)
        WALK_KIND: begin
          if (p == int'(next_start)) begin
            mss_cand = (it.option_byte == KIND_MSS && int'(opt_len) >= p + int'(LEN_MSS));
            if (it.option_byte < 8'd2) next_start = 9'(p + 1);
            else walk_phase = WALK_LEN;
          end
        end
        WALK_LEN: begin
          if (mss_cand && it.option_byte == LEN_MSS) begin
            walk_phase = WALK_MSS_HI;
          end else begin
            // a length of zero or one makes the option end with this byte
            next_start = (it.option_byte <= 8'd1) ? 9'(p + 1) :
                                                    9'(p - 1 + int'(it.option_byte));
            walk_phase = WALK_KIND;
          end
          mss_cand = 1'b0;
        end
        WALK_MSS_HI: begin
          mss_hi_byte = it.option_byte;
          walk_phase  = WALK_MSS_LO;
        end
        WALK_MSS_LO: begin
          mss           = {mss_hi_byte, it.option_byte};
          verdict_held  = (mss >= lim_lo && mss <= lim_hi) ^ lim_inv;
          verdict_known = 1'b1;
          walk_phase    = WALK_DRAIN;
        end
        default: ;
      endcase
      if (p + 1 >= int'(opt_len)) begin
        r.matched = verdict_known ? verdict_held : lim_inv;
        emit      = 1;
      end else if (it.last_available) begin
        r.drop = 1'b1;
        emit   = 1;
      end else begin
        byte_pos = 6'(p + 1);
      end
    end
    if (emit) begin
      walk_phase = WALK_IDLE;
      verdict_q.push_back(r);
    end
  endtask

  // Check each result transfer against the oldest verdict waiting.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual matched=%0b drop=%0b",
                 $time, out_if.data.matched, out_if.data.drop);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_if.data.matched !== want.matched) begin
          $display("%0t: matched mismatch: expected %0b, actual %0b",
                   $time, want.matched, out_if.data.matched);
          mismatches++;
        end
        if (out_if.data.drop !== want.drop) begin
          $display("%0t: drop mismatch: expected %0b, actual %0b",
                   $time, want.drop, out_if.data.drop);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        out_if.ready <= 1'b0;
        repeat (80) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic item_t make_header(logic [3:0] doff, logic complete, logic last);
    item_t it;
    it.op              = OP_HEADER;
    it.data_offset     = doff;
    it.header_complete = complete;
    it.option_byte     = 8'($urandom);
    it.last_available  = last;
    return it;
  endfunction

  function automatic item_t make_option(logic [7:0] b, logic last);
    item_t it;
    it.op              = OP_OPTION;
    it.data_offset     = 4'($urandom);
    it.header_complete = 1'($urandom);
    it.option_byte     = b;
    it.last_available  = last;
    return it;
  endfunction

  function automatic logic [15:0] pick_mss();
    case ($urandom_range(0, 6))
      0:       return lim_lo;
      1:       return lim_hi;
      2:       return lim_lo - 16'd1;
      3:       return lim_hi + 16'd1;
      4:       return 16'h0000;
      5:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(item_t it);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    predict_verdict(it);
  endtask

  task automatic send_strays(int unsigned n);
    repeat (n) send_item(make_option(8'($urandom), 1'($urandom)));
  endtask

  // Header, then the first count bytes of opt_area; last_available on byte cut.
  task automatic send_packet(logic [3:0] doff, int count, int cut);
    send_item(make_header(doff, 1'b1, 1'b0));
    for (int i = 0; i < count; i++) begin
      send_item(make_option(opt_area[i], i == cut));
      if (i == cut) break;
    end
  endtask

  task automatic fill_options(int unsigned len);
    int unsigned rem;
    int unsigned olen;
    logic [15:0] mss;
    opt_area.delete();
    while (opt_area.size() < len) begin
      rem = len - opt_area.size();
      case ($urandom_range(0, 10))
        0: opt_area.push_back(8'd0);
        1: opt_area.push_back(8'd1);
        2, 3, 4, 5: begin
          mss = pick_mss();
          opt_area.push_back(KIND_MSS);
          opt_area.push_back(LEN_MSS);
          opt_area.push_back(mss[15:8]);
          opt_area.push_back(mss[7:0]);
        end
        6: begin
          olen = $urandom_range(2, rem + 3);
          opt_area.push_back(8'($urandom_range(3, 255)));
          opt_area.push_back(8'(olen));
          repeat (olen - 2) opt_area.push_back(8'($urandom));
        end
        7: begin
          opt_area.push_back(8'($urandom_range(2, 255)));
          opt_area.push_back(8'($urandom_range(0, 1)));
        end
        8: opt_area.push_back(8'($urandom));
        9: begin
          // length reaching or running past the end of the area
          opt_area.push_back(8'($urandom_range(3, 255)));
          opt_area.push_back(8'($urandom_range(rem, 255)));
        end
        default: begin
          opt_area.push_back(KIND_MSS);
          opt_area.push_back(8'($urandom));
        end
      endcase
    end
    while (opt_area.size() > len) void'(opt_area.pop_back());
  endtask

  task automatic random_packet();
    logic [3:0]  doff;
    int unsigned len;
    int          cut;
    doff = ($urandom_range(0, 9) == 0) ? MIN_DATA_OFFSET : 4'($urandom_range(6, 15));
    len  = (int'(doff) - int'(MIN_DATA_OFFSET)) * 4;
    fill_options(len);
    case ($urandom_range(0, 19))
      0: begin
        send_item(make_header(4'($urandom), 1'b0, 1'($urandom)));
        send_strays($urandom_range(0, 2));
      end
      1: begin
        send_item(make_header(4'($urandom_range(0, 4)), 1'($urandom), 1'($urandom)));
        send_strays($urandom_range(0, 2));
      end
      2: send_strays($urandom_range(1, 3));
      3: send_item(make_header(doff, 1'b1, 1'b1));
      4: send_packet(doff, (len > 0) ? $urandom_range(0, len - 1) : 0, -1);
      5, 6: begin
        cut = (len > 1) ? $urandom_range(0, len - 2) : -1;
        send_packet(doff, cut + 1, cut);
      end
      default: send_packet(doff, len, $urandom_range(0, 1) ? int'(len) - 1 : -1);
    endcase
  endtask

  // Close any open packet, let every verdict arrive, then allow the pipe to empty.
  task automatic wait_idle();
    if (walk_phase != WALK_IDLE) send_item(make_header(MIN_DATA_OFFSET, 1'b1, 1'b0));
    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(logic [15:0] lo, logic [15:0] hi, logic inv);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MSS_LOWER;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_MSS_UPPER;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= REG_INVERT_SENSE;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, inv};
    @(posedge clk);
    cfg_we  <= 1'b0;
    lim_lo  = lo;
    lim_hi  = hi;
    lim_inv = inv;
  endtask

  task automatic apply_reset();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    lim_lo        = 16'h0000;
    lim_hi        = 16'hFFFF;
    lim_inv       = 1'b0;
    opt_len       = '0;
    byte_pos      = '0;
    next_start    = '0;
    walk_phase    = WALK_IDLE;
    mss_cand      = 1'b0;
    mss_hi_byte   = '0;
    verdict_held  = 1'b0;
    verdict_known = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_header_verdicts();
    send_item(make_header(4'd15, 1'b0, 1'b0));
    send_item(make_header(4'd4, 1'b1, 1'b0));
    send_item(make_option(8'hFF, 1'b1));
    // open a packet, then abandon it with a fresh header
    send_item(make_header(4'd6, 1'b1, 1'b0));
    send_item(make_option(8'd1, 1'b0));
    send_item(make_header(MIN_DATA_OFFSET, 1'b1, 1'b1));
    send_item(make_header(4'd6, 1'b1, 1'b1));
    send_item(make_header(4'd0, 1'b1, 1'b0));
  endtask

  task automatic test_option_walk();
    opt_area = '{KIND_MSS, LEN_MSS, 8'hFF, 8'hFF};
    send_packet(4'd6, 4, 3);
    // NOP, EOL, zero length, then an MSS of zero ending the area
    opt_area = '{8'd1, 8'd0, 8'd3, 8'd0, KIND_MSS, LEN_MSS, 8'h00, 8'h00};
    send_packet(4'd7, 8, -1);
    // truncated after a complete MSS option
    opt_area = '{KIND_MSS, LEN_MSS, 8'h05, 8'hB4, 8'd1, 8'd1, 8'd1, 8'd1};
    send_packet(4'd7, 6, 5);
  endtask

  task automatic test_random_traffic(int unsigned target);
    while (useful_items < target) begin
      idle_on  = ($urandom_range(0, 4) != 0);
      stall_on = ($urandom_range(0, 4) != 0);
      random_packet();
    end
  endtask

  task automatic test_limit_settings();
    logic [15:0] lo_r;
    logic [15:0] hi_r;
    lo_r = 16'($urandom);
    hi_r = 16'($urandom);
    test_random_traffic(useful_items + 200);
    wait_idle();
    set_limits(16'd1000, 16'd1460, 1'b0);
    test_random_traffic(useful_items + 200);
    wait_idle();
    set_limits(16'd536, 16'd9000, 1'b1);
    test_random_traffic(useful_items + 200);
    wait_idle();
    set_limits(16'hFFFF, 16'hFFFF, 1'b0);
    test_random_traffic(useful_items + 200);
    wait_idle();
    set_limits(16'h0000, 16'h0000, 1'b1);
    test_random_traffic(useful_items + 200);
    wait_idle();
    set_limits(lo_r, hi_r, 1'($urandom));
    test_random_traffic(useful_items + 200);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    idle_on       = 1;
    long_hold_req = 1;
    repeat (12) send_item(make_header(MIN_DATA_OFFSET, 1'b1, 1'($urandom)));
    wait_idle();
  endtask

  task automatic test_back_to_back();
    idle_on  = 0;
    stall_on = 0;
    set_limits(16'd1200, 16'd1500, 1'b0);
    while (useful_items < 1520) random_packet();
  endtask

  initial begin
    int guard;
    mismatches    = 0;
    useful_items  = 0;
    idle_on       = 1;
    stall_on      = 1;
    long_hold_req = 0;
    apply_reset();
    test_header_verdicts();
    test_option_walk();
    test_limit_settings();
    test_output_backpressure();
    test_back_to_back();
    in_if.valid <= 1'b0;
    guard = 0;
    while (verdict_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tcp_mss_option_range_match verification clean");
    end else begin
      $display("tcp_mss_option_range_match verification failed");
    end
    $finish;
  end

endmodule

// ----- tcp_mss_option_range_match.f -----
rtl/core/tmor_pkg.sv
rtl/core/tmor_stream_if.sv
rtl/core/tmor_walker.sv
rtl/core/tcp_mss_option_range_match.sv
test/tcp_mss_option_range_match_test.sv
